FILE: hw/rtl/star_learning_switch_forwarder_core_assert.svh
// assertion macros used by the checker file
`ifndef STAR_LEARNING_SWITCH_FORWARDER_CORE_ASSERT_SVH
`define STAR_LEARNING_SWITCH_FORWARDER_CORE_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define SLSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SLSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/slsf_pkg.sv
// ----------------------------------------------------------------------------
// slsf_pkg
// Types and constants shared by the learning switch forwarder modules.
// ----------------------------------------------------------------------------
package slsf_pkg;

    localparam int MAC_W       = 48;
    localparam int NODE_W      = 3;
    localparam int PORT_W      = 2;
    localparam int MASK_W      = 4;
    localparam int SPOKE_W     = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MAC_W-1:0] MAC_BCAST = '1;

    typedef enum logic [1:0] {
        NODE_SPOKE,
        NODE_HUB,
        NODE_NONE
    } t_node_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } t_back_state;

    typedef struct packed {
        t_node_kind              kind;
        logic [NODE_W-1:0]       node;
        logic                    local_seg;
        logic                    learn;
        logic                    bcast;
        logic                    src_eq_dst;
        logic                    scan;
        logic [MASK_W-1:0]       bcast_mask;
        logic [MASK_W-1:0]       flood_mask;
        logic [MAC_W-1:0]        src_mac;
        logic [MAC_W-1:0]        dst_mac;
    } t_cmd;

    typedef struct packed {
        logic [MAC_W-1:0]        mac;
        logic [SPOKE_W-1:0]      spoke;
    } t_entry;

    typedef struct packed {
        logic                    to_hub;
        logic                    to_local;
        logic [MASK_W-1:0]       hub_port_mask;
        logic                    learn_full;
    } t_result;

endpackage

FILE: hw/rtl/star_learning_switch_forwarder_core.sv
// ----------------------------------------------------------------------------
// star_learning_switch_forwarder_core
// Forwarding decision for a hub-and-spoke layer-2 learning switch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one header word: node id,
//   local flag, hub ingress port and the source and destination macs.
//   Output channel (o_out_valid / i_out_ready) returns one decision word per
//   header: to_hub, to_local, hub port mask and the learn-full flag.
//   i_cfg_we / i_cfg_wdata write the port-present mask; write it only while
//   no header is in flight.
//   The table engine works on one header at a time; it scans the learned
//   entries of the mac table through its single read port, one entry per
//   cycle, and a word with no scan, or an empty table, skips the scan.
//   A two-entry command queue keeps accepting headers while the table engine
//   works, and the engine finishes into an output register.
//   Reset empties the mac table at once (fill count) and sets port-present to
//   all ones. A stalled receiver holds the result; the engine waits for the
//   output register and the queue fills, then o_in_ready drops.
// ----------------------------------------------------------------------------
module star_learning_switch_forwarder_core
    import slsf_pkg::*;
#(
    parameter int SPOKES        = 4,
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [NODE_W-1:0]   i_node_id,
    input  logic                i_from_local,
    input  logic [PORT_W-1:0]   i_in_port,
    input  logic [MAC_W-1:0]    i_src_mac,
    input  logic [MAC_W-1:0]    i_dst_mac,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_to_hub,
    output logic                o_to_local,
    output logic [MASK_W-1:0]   o_hub_port_mask,
    output logic                o_learn_full,
    input  logic                i_cfg_we,
    input  logic [MASK_W-1:0]   i_cfg_wdata
);

    logic [MASK_W-1:0] r_port_present;
    logic              q_full;
    logic              q_push;
    t_cmd              front_cmd;
    logic              q_pop;
    logic              q_valid;
    t_cmd              q_cmd;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_present <= {MASK_W{1'b1}};
        end else if (i_cfg_we) begin
            r_port_present <= i_cfg_wdata;
        end
    end

    slsf_front #(
        .SPOKES (SPOKES)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_node_id      (i_node_id),
        .i_from_local   (i_from_local),
        .i_in_port      (i_in_port),
        .i_src_mac      (i_src_mac),
        .i_dst_mac      (i_dst_mac),
        .i_port_present (r_port_present),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (front_cmd)
    );

    slsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    slsf_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_to_hub        = res.to_hub;
    assign o_to_local      = res.to_local;
    assign o_hub_port_mask = res.hub_port_mask;
    assign o_learn_full    = res.learn_full;

endmodule

FILE: hw/rtl/slsf_front.sv
// ----------------------------------------------------------------------------
// slsf_front
// Takes header words and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module slsf_front
    import slsf_pkg::*;
#(
    parameter int SPOKES = 4
) (
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [NODE_W-1:0]   i_node_id,
    input  logic                i_from_local,
    input  logic [PORT_W-1:0]   i_in_port,
    input  logic [MAC_W-1:0]    i_src_mac,
    input  logic [MAC_W-1:0]    i_dst_mac,
    input  logic [MASK_W-1:0]   i_port_present,
    input  logic                i_q_full,
    output logic                o_push,
    output t_cmd                o_cmd
);

    localparam logic [MASK_W-1:0] ALL_PORTS =
        (SPOKES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << SPOKES) - 1);

    logic              is_hub;
    logic              is_spoke;
    logic [MASK_W-1:0] in_bit;

    always_comb begin
        is_hub   = (int'(i_node_id) == SPOKES);
        is_spoke = (int'(i_node_id) < SPOKES);
        in_bit   = MASK_W'(1) << i_in_port;

        o_cmd.kind       = is_hub ? NODE_HUB : (is_spoke ? NODE_SPOKE : NODE_NONE);
        o_cmd.node       = i_node_id;
        o_cmd.local_seg  = i_from_local;
        o_cmd.learn      = is_spoke && i_from_local && (i_src_mac != MAC_BCAST);
        o_cmd.bcast      = (i_dst_mac == MAC_BCAST);
        o_cmd.src_eq_dst = (i_src_mac == i_dst_mac);
        o_cmd.scan       = (is_hub || is_spoke) && (o_cmd.learn || !o_cmd.bcast);
        o_cmd.bcast_mask = i_port_present & ALL_PORTS & ~in_bit;
        o_cmd.flood_mask = ALL_PORTS & ~in_bit;
        o_cmd.src_mac    = i_src_mac;
        o_cmd.dst_mac    = i_dst_mac;
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

FILE: hw/rtl/slsf_queue.sv
// ----------------------------------------------------------------------------
// slsf_queue
// Short command queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module slsf_queue
    import slsf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_fill;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_fill;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && i_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_fill == CW'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

endmodule

FILE: hw/rtl/slsf_back.sv
// ----------------------------------------------------------------------------
// slsf_back
// Table engine: scans the mac table, learns the source, decides forwarding.
// ----------------------------------------------------------------------------
module slsf_back
    import slsf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cmd    i_q_cmd,
    output logic    o_q_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_res
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // table storage, filled from entry zero upward, never freed
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    t_back_state        r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [CW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_count, n_count;
    logic               r_pend, n_pend;
    logic               r_src_hit, n_src_hit;
    logic [AW-1:0]      r_src_idx, n_src_idx;
    logic               r_dst_hit, n_dst_hit;
    logic [SPOKE_W-1:0] r_dst_spoke, n_dst_spoke;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               issue;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    t_entry             mem_wd;
    logic               room;
    logic               learn_ok;
    logic               learn_full;
    logic               hit;
    logic [SPOKE_W-1:0] hit_spoke;
    logic               own;
    t_result            res;

    // decision from the scan results
    always_comb begin
        room       = (r_count < CW'(TABLE_ENTRIES));
        learn_ok   = r_cmd.learn && (r_src_hit || room);
        learn_full = r_cmd.learn && !r_src_hit && !room;
        if (r_cmd.bcast) begin
            hit       = 1'b0;
            hit_spoke = r_dst_spoke;
        end else if (learn_ok && r_cmd.src_eq_dst) begin
            hit       = 1'b1;
            hit_spoke = r_cmd.node[SPOKE_W-1:0];
        end else begin
            hit       = r_dst_hit;
            hit_spoke = r_dst_spoke;
        end
        own = (NODE_W'(hit_spoke) == r_cmd.node);

        res = '0;
        res.learn_full = learn_full;
        case (r_cmd.kind)
            NODE_HUB: begin
                if (r_cmd.bcast) begin
                    res.hub_port_mask = r_cmd.bcast_mask;
                end else if (hit) begin
                    res.hub_port_mask = MASK_W'(1) << hit_spoke;
                end else begin
                    res.hub_port_mask = r_cmd.flood_mask;
                end
            end
            NODE_SPOKE: begin
                if (hit) begin
                    res.to_local = own && !r_cmd.local_seg;
                    res.to_hub   = !own && r_cmd.local_seg;
                end else begin
                    res.to_local = !r_cmd.local_seg;
                    res.to_hub   = r_cmd.local_seg;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_count     = r_count;
        n_pend      = 1'b0;
        n_src_hit   = r_src_hit;
        n_src_idx   = r_src_idx;
        n_dst_hit   = r_dst_hit;
        n_dst_spoke = r_dst_spoke;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        issue       = 1'b0;
        rd_addr     = r_addr[AW-1:0];
        mem_we      = 1'b0;
        mem_wa      = r_src_hit ? r_src_idx : r_count[AW-1:0];
        mem_wd.mac  = r_cmd.src_mac;
        mem_wd.spoke = r_cmd.node[SPOKE_W-1:0];

        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_cmd     = i_q_cmd;
                    n_addr    = '0;
                    n_src_hit = 1'b0;
                    n_dst_hit = 1'b0;
                    n_state   = BK_SCAN;
                end
            end
            BK_SCAN: begin
                issue  = r_cmd.scan && (r_addr < r_count);
                n_pend = issue;
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                // compare the word read in the previous cycle
                if (r_pend) begin
                    if (!r_src_hit && r_rd_data.mac == r_cmd.src_mac) begin
                        n_src_hit = 1'b1;
                        n_src_idx = AW'(r_addr - 1'b1);
                    end
                    if (!r_dst_hit && r_rd_data.mac == r_cmd.dst_mac) begin
                        n_dst_hit   = 1'b1;
                        n_dst_spoke = r_rd_data.spoke;
                    end
                end
                if (!issue && !r_pend) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    mem_we      = learn_ok;
                    if (learn_ok && !r_src_hit) begin
                        n_count = r_count + 1'b1;
                    end
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_addr      <= n_addr;
        r_src_hit   <= n_src_hit;
        r_src_idx   <= n_src_idx;
        r_dst_hit   <= n_dst_hit;
        r_dst_spoke <= n_dst_spoke;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

FILE: hw/rtl/slsf_checker.sv
// ----------------------------------------------------------------------------
// slsf_checker
// Port-level checks on the forwarder core, attached by bind.
// ----------------------------------------------------------------------------
`include "star_learning_switch_forwarder_core_assert.svh"

module slsf_checker
    import slsf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_to_hub,
    input logic                o_to_local,
    input logic [MASK_W-1:0]   o_hub_port_mask,
    input logic                o_learn_full
);

    logic              stalled;
    logic [MASK_W+2:0] out_word;
    logic              mask_zero;
    logic              spoke_fwd;
    logic              both_fwd;
    logic              full_word;

    assign stalled   = o_out_valid && !i_out_ready;
    assign out_word  = {o_to_hub, o_to_local, o_hub_port_mask, o_learn_full};
    assign mask_zero = (o_hub_port_mask == '0);
    assign spoke_fwd = o_out_valid && (o_to_hub || o_to_local);
    assign both_fwd  = o_to_hub && o_to_local;
    assign full_word = o_out_valid && o_learn_full;

    // stalled word stays
    `SLSF_ASSERT(a_out_hold, stalled |=> o_out_valid, "output word dropped while stalled")

    `SLSF_ASSERT(a_out_stable, stalled |=> $stable(out_word), "output word changed while stalled")

    // a spoke never both sends up and delivers, and spoke words carry no mask
    `SLSF_ASSERT(a_spoke_excl, spoke_fwd |-> !both_fwd && mask_zero, "conflicting decision")

    // only a local-segment frame at a spoke can fail to learn
    `SLSF_ASSERT(a_full_local, full_word |-> !o_to_local && mask_zero, "learn full off a spoke")

    `SLSF_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind star_learning_switch_forwarder_core slsf_checker u_slsf_checker (.*);
